// ===== src/token_bucket_packet_gate_assert.svh =====
// Assertion macros for the token bucket packet gate.
// Expects clk and rst_n in the scope of use; empty when SYNTHESIS is set.
`ifndef TOKEN_BUCKET_PACKET_GATE_ASSERT_SVH
`define TOKEN_BUCKET_PACKET_GATE_ASSERT_SVH
`ifndef SYNTHESIS
`define TBG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("token bucket gate assertion failed");
`define TBG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("token bucket gate assertion failed");
`else
`define TBG_ASSERT_IMP(lbl, ante, cons)
`define TBG_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/tbg_pkg.sv =====
// Shared types and constants of the token bucket packet gate.
// No dependencies.
`timescale 1ns / 1ps
package tbg_pkg;
  localparam int REQ_W           = 10;
  localparam int ID_W            = 16;
  localparam int STATUS_W        = 3;
  localparam int ENTRY_W         = ID_W + REQ_W;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int CMD_DEPTH       = 2;
  localparam int CMD_PTR_W       = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W       = $clog2(CMD_DEPTH + 1);
  localparam logic [REQ_W-1:0] DEPTH_RESET = REQ_W'(10);

  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED,
    ST_TOO_BIG,
    ST_FULL,
    ST_TOKEN_ADDED,
    ST_TOKEN_DROPPED
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } bk_state_t;

  typedef struct packed {
    logic             kind;
    logic [REQ_W-1:0] request;
    logic [ID_W-1:0]  packet_id;
    logic             too_big;
  } cmd_t;
endpackage

// ===== src/tbg_if.sv =====
// Channel interfaces of the token bucket packet gate: event in, result out, config.
// Depends on tbg_pkg.
`timescale 1ns / 1ps
interface tbg_in_if;
  import tbg_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [REQ_W-1:0] request;
  modport source(output valid, kind, request, input ready);
  modport sink(input valid, kind, request, output ready);
endinterface

interface tbg_out_if #(
  parameter int QUEUE_DEPTH = tbg_pkg::QUEUE_DEPTH_DEF
);
  import tbg_pkg::*;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     packet_id;
  logic                released;
  logic [ID_W-1:0]     released_id;
  logic [REQ_W-1:0]    released_request;
  logic [REQ_W-1:0]    tokens_now;
  logic [CNT_W-1:0]    queue_count;
  modport source(output valid, status, packet_id, released, released_id,
                 released_request, tokens_now, queue_count, input ready);
  modport sink(input valid, status, packet_id, released, released_id,
               released_request, tokens_now, queue_count, output ready);
endinterface

interface tbg_cfg_if;
  import tbg_pkg::*;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== src/tbg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end
endmodule

// ===== src/tbg_front.sv =====
// Front end: accepts event words, assigns packet ids, flags oversize requests.
// Depends on tbg_pkg and tbg_if.
`timescale 1ns / 1ps
module tbg_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [tbg_pkg::REQ_W-1:0] bucket_depth,
  tbg_in_if.sink                    in_ch,
  output tbg_pkg::cmd_t             cmd,
  output logic                      cmd_valid,
  input  logic                      cmd_ready
);
  import tbg_pkg::*;

  logic [ID_W-1:0] next_id_r;
  logic [ID_W-1:0] next_id_nxt;
  logic [ID_W-1:0] id_inc;
  logic            is_arrival;

  assign id_inc     = next_id_r + ID_W'(1);
  assign is_arrival = (in_ch.kind == KIND_ARRIVAL);

  assign in_ch.ready = cmd_ready;
  assign cmd_valid   = in_ch.valid;

  always_comb begin
    cmd.kind      = in_ch.kind;
    cmd.request   = in_ch.request;
    cmd.packet_id = is_arrival ? id_inc : '0;
    cmd.too_big   = is_arrival && (in_ch.request > bucket_depth);
  end

  always_comb begin
    next_id_nxt = next_id_r;
    if (in_ch.valid && cmd_ready && is_arrival) begin
      next_id_nxt = id_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_id_r <= '0;
    end else begin
      next_id_r <= next_id_nxt;
    end
  end
endmodule

// ===== src/tbg_cmd_fifo.sv =====
// Short command queue between front and back end.
// Depends on tbg_pkg.
`timescale 1ns / 1ps
module tbg_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  tbg_pkg::cmd_t push_cmd,
  input  logic          push_valid,
  output logic          push_ready,
  output tbg_pkg::cmd_t pop_cmd,
  output logic          pop_valid,
  input  logic          pop_ready
);
  import tbg_pkg::*;

  localparam logic [CMD_PTR_W-1:0] LAST_PTR = CMD_PTR_W'(CMD_DEPTH - 1);
  localparam logic [CMD_CNT_W-1:0] FULL_CNT = CMD_CNT_W'(CMD_DEPTH);

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_r, wr_nxt;
  logic [CMD_PTR_W-1:0] rd_r, rd_nxt;
  logic [CMD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == LAST_PTR) ? '0 : wr_r + CMD_PTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == LAST_PTR) ? '0 : rd_r + CMD_PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CMD_CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CMD_CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end
endmodule

// ===== src/tbg_back.sv =====
// Back end: token count, waiting-packet FIFO in RAM, result register.
// Depends on tbg_pkg, tbg_if and tbg_ram.
`timescale 1ns / 1ps
module tbg_back #(
  parameter int QUEUE_DEPTH = tbg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [tbg_pkg::REQ_W-1:0] bucket_depth,
  input  tbg_pkg::cmd_t             cmd,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  tbg_out_if.source                 out_ch
);
  import tbg_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  bk_state_t        state_r, state_nxt;
  logic [REQ_W-1:0] tokens_r, tokens_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  status_t          pend_status_r, pend_status_nxt;

  logic             ov_r, ov_nxt;
  status_t          o_status_r, o_status_nxt;
  logic [ID_W-1:0]  o_pid_r, o_pid_nxt;
  logic             o_rel_r, o_rel_nxt;
  logic [ID_W-1:0]  o_rid_r, o_rid_nxt;
  logic [REQ_W-1:0] o_rreq_r, o_rreq_nxt;
  logic [REQ_W-1:0] o_tok_r, o_tok_nxt;
  logic [CNT_W-1:0] o_cnt_r, o_cnt_nxt;

  logic               ram_we, ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [REQ_W-1:0]   head_need;
  logic [REQ_W-1:0]   tick_tokens;
  status_t            tick_status;
  logic               slot_free;
  logic               load;

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  tbg_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_wait_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail_r),
    .wdata({cmd.packet_id, cmd.request}),
    .re   (ram_re),
    .raddr(head_r),
    .rdata(ram_rdata)
  );

  assign slot_free   = !ov_r || out_ch.ready;
  assign head_need   = ram_rdata[REQ_W-1:0];
  assign tick_tokens = (tokens_r < bucket_depth) ? tokens_r + REQ_W'(1) : tokens_r;
  assign tick_status = (tokens_r < bucket_depth) ? ST_TOKEN_ADDED : ST_TOKEN_DROPPED;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && slot_free && (cmd.kind == KIND_TICK) && (count_r != '0)) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    tokens_nxt      = tokens_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    pend_status_nxt = pend_status_r;
    cmd_ready       = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    load            = 1'b0;
    o_status_nxt    = o_status_r;
    o_pid_nxt       = o_pid_r;
    o_rel_nxt       = 1'b0;
    o_rid_nxt       = '0;
    o_rreq_nxt      = '0;
    case (state_r)
      BK_IDLE: begin
        cmd_ready = slot_free;
        if (cmd_valid && slot_free) begin
          o_pid_nxt = cmd.packet_id;
          if (cmd.kind == KIND_ARRIVAL) begin
            load = 1'b1;
            if (cmd.too_big) begin
              o_status_nxt = ST_TOO_BIG;
            end else if (count_r >= FULL_CNT) begin
              o_status_nxt = ST_FULL;
            end else begin
              o_status_nxt = ST_QUEUED;
              ram_we       = 1'b1;
              tail_nxt     = adv(tail_r);
              if ((count_r == '0) && (tokens_r >= cmd.request)) begin
                tokens_nxt = tokens_r - cmd.request;
                head_nxt   = adv(head_r);
                o_rel_nxt  = 1'b1;
                o_rid_nxt  = cmd.packet_id;
                o_rreq_nxt = cmd.request;
              end else begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
          end else begin
            tokens_nxt   = tick_tokens;
            o_status_nxt = tick_status;
            if (count_r == '0) begin
              load = 1'b1;
            end else begin
              ram_re          = 1'b1;
              pend_status_nxt = tick_status;
            end
          end
        end
      end
      BK_READ: begin
        if (slot_free) begin
          load         = 1'b1;
          o_status_nxt = pend_status_r;
          o_pid_nxt    = '0;
          if (tokens_r >= head_need) begin
            tokens_nxt = tokens_r - head_need;
            head_nxt   = adv(head_r);
            count_nxt  = count_r - CNT_W'(1);
            o_rel_nxt  = 1'b1;
            o_rid_nxt  = ram_rdata[ENTRY_W-1:REQ_W];
            o_rreq_nxt = head_need;
          end
        end
      end
      default: begin
      end
    endcase
    o_tok_nxt = tokens_nxt;
    o_cnt_nxt = count_nxt;
    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      tokens_r <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tokens_r <= tokens_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    if (load) begin
      o_status_r <= o_status_nxt;
      o_pid_r    <= o_pid_nxt;
      o_rel_r    <= o_rel_nxt;
      o_rid_r    <= o_rid_nxt;
      o_rreq_r   <= o_rreq_nxt;
      o_tok_r    <= o_tok_nxt;
      o_cnt_r    <= o_cnt_nxt;
    end
  end

  assign out_ch.valid            = ov_r;
  assign out_ch.status           = o_status_r;
  assign out_ch.packet_id        = o_pid_r;
  assign out_ch.released         = o_rel_r;
  assign out_ch.released_id      = o_rid_r;
  assign out_ch.released_request = o_rreq_r;
  assign out_ch.tokens_now       = o_tok_r;
  assign out_ch.queue_count      = o_cnt_r;
endmodule

// ===== src/token_bucket_packet_gate.sv =====
// Token bucket packet gate, top level: config register, front end, command
// queue, back end. Depends on tbg_pkg, tbg_if and all tbg_* modules.
// Channels: in_ch takes event words (kind 0 packet arrival with its token
// request, kind 1 token tick); out_ch gives one result word per event;
// cfg_ch writes bucket_depth and is always ready; the user must write it
// only while the block is idle, as the block itself has no check for it.
// Events pass through the command queue to the back end's result register;
// a tick that finds packets waiting first does a registered read of the
// head entry from the wait RAM. Throughput: one event per cycle while the
// receiver takes results, except such a tick, which holds the back end.
// Reset: token count, queue pointers, packet ids clear; bucket_depth is 10.
// Receiver stall: the result register holds; the two-entry command queue
// fills, then in_ch.ready drops until the result word is taken.
`timescale 1ns / 1ps
`include "token_bucket_packet_gate_assert.svh"
module token_bucket_packet_gate #(
  parameter int QUEUE_DEPTH = tbg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tbg_cfg_if.sink   cfg_ch,
  tbg_in_if.sink    in_ch,
  tbg_out_if.source out_ch
);
  import tbg_pkg::*;

  logic [REQ_W-1:0] depth_r, depth_nxt;
  cmd_t             front_cmd, back_cmd;
  logic             front_valid, front_ready;
  logic             back_valid, back_ready;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    depth_nxt = depth_r;
    if (cfg_ch.valid) begin
      depth_nxt = cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= DEPTH_RESET;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  tbg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .bucket_depth(depth_r),
    .in_ch       (in_ch),
    .cmd         (front_cmd),
    .cmd_valid   (front_valid),
    .cmd_ready   (front_ready)
  );

  tbg_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cmd  (front_cmd),
    .push_valid(front_valid),
    .push_ready(front_ready),
    .pop_cmd   (back_cmd),
    .pop_valid (back_valid),
    .pop_ready (back_ready)
  );

  tbg_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .bucket_depth(depth_r),
    .cmd         (back_cmd),
    .cmd_valid   (back_valid),
    .cmd_ready   (back_ready),
    .out_ch      (out_ch)
  );

  `TBG_ASSERT_IMP(a_tick_no_id, back_valid && (back_cmd.kind == KIND_TICK), back_cmd.packet_id == '0)
  `TBG_ASSERT_IMP(a_drop_no_release, out_ch.valid && ((out_ch.status == ST_TOO_BIG) || (out_ch.status == ST_FULL)), !out_ch.released)
  `TBG_ASSERT_IMP(a_direct_release, out_ch.valid && out_ch.released && (out_ch.status == ST_QUEUED), (out_ch.released_id == out_ch.packet_id) && (out_ch.queue_count == '0))
  `TBG_ASSERT_NXT(a_stall_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.tokens_now))
endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for token_bucket_packet_gate: directed table, then random event phases
// across bucket depths, each result word checked against a literal row or an in-bench predictor.
// Depends on tbg_pkg, the tbg_* channel interfaces and the gate RTL.
`timescale 1ns / 1ps
module tb_top;
  import tbg_pkg::*;

  localparam int QDEPTH         = QUEUE_DEPTH_DEF;
  localparam int CNT_W          = $clog2(QDEPTH + 1);
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int IDLE_PAUSE     = 4;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PHASE_ITEMS    = 50;
  localparam int NUM_PHASES     = 9;
  localparam int SQUEEZE_AFTER  = 150;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  packet_id;
    logic             released;
    logic [ID_W-1:0]  released_id;
    logic [REQ_W-1:0] released_request;
    logic [REQ_W-1:0] tokens_now;
    logic [CNT_W-1:0] queue_count;
  } gate_result_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [REQ_W-1:0] need;
  } held_pkt_t;

  typedef struct packed {
    logic             set_depth;
    logic [REQ_W-1:0] depth_val;
    logic             kind;
    logic [REQ_W-1:0] request;
    logic             literal;
    gate_result_t     want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  tbg_in_if                               in_ch();
  tbg_out_if #(.QUEUE_DEPTH(QDEPTH))      out_ch();
  tbg_cfg_if                              cfg_ch();

  token_bucket_packet_gate #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [REQ_W-1:0] bucket_depth;
  logic [REQ_W-1:0] bucket_tokens;
  logic [ID_W-1:0]  id_counter;
  held_pkt_t        held_q[$];

  gate_result_t pending_results[$];
  plan_row_t    plan[$];
  int           mismatches = 0;
  int           results_seen = 0;
  int           cycle_count = 0;
  bit           quiet_link = 1'b0;
  bit           squeeze_done = 1'b0;

  function automatic void try_release(inout gate_result_t r);
    if (held_q.size() != 0 && bucket_tokens >= held_q[0].need) begin
      bucket_tokens      = bucket_tokens - held_q[0].need;
      r.released         = 1'b1;
      r.released_id      = held_q[0].id;
      r.released_request = held_q[0].need;
      void'(held_q.pop_front());
    end
  endfunction

  function automatic gate_result_t gate_predict(logic kind, logic [REQ_W-1:0] req);
    gate_result_t r;
    held_pkt_t    p;
    r = '0;
    if (kind == KIND_ARRIVAL) begin
      id_counter  = id_counter + ID_W'(1);
      r.packet_id = id_counter;
      if (req > bucket_depth) begin
        r.status = ST_TOO_BIG;
      end else if (held_q.size() >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        r.status = ST_QUEUED;
        p.id     = id_counter;
        p.need   = req;
        held_q.push_back(p);
        if (held_q.size() == 1) try_release(r);
      end
    end else begin
      if (bucket_tokens < bucket_depth) begin
        bucket_tokens = bucket_tokens + REQ_W'(1);
        r.status      = ST_TOKEN_ADDED;
      end else begin
        r.status = ST_TOKEN_DROPPED;
      end
      try_release(r);
    end
    r.tokens_now  = bucket_tokens;
    r.queue_count = CNT_W'(held_q.size());
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_link || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [REQ_W-1:0] pick_request(logic [REQ_W-1:0] d);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return (d == '1) ? '1 : REQ_W'($urandom_range(int'(d) + 1, 1023));
    if (r < 24) return REQ_W'($urandom_range(0, 1023));
    if (r < 30) return d;
    return REQ_W'($urandom_range(0, (d < 8) ? int'(d) : 8));
  endfunction

  function automatic plan_row_t step_row(logic kind, logic [REQ_W-1:0] req);
    plan_row_t row;
    row         = '0;
    row.kind    = kind;
    row.request = req;
    return row;
  endfunction

  function automatic plan_row_t depth_row(logic [REQ_W-1:0] d);
    plan_row_t row;
    row           = '0;
    row.set_depth = 1'b1;
    row.depth_val = d;
    return row;
  endfunction

  function automatic plan_row_t lit_row(logic kind, logic [REQ_W-1:0] req, status_t st,
                                        int pid, bit rel, int rid, int rreq, int tok, int qc);
    plan_row_t row;
    row                       = step_row(kind, req);
    row.literal               = 1'b1;
    row.want.status           = st;
    row.want.packet_id        = ID_W'(pid);
    row.want.released         = rel;
    row.want.released_id      = ID_W'(rid);
    row.want.released_request = REQ_W'(rreq);
    row.want.tokens_now       = REQ_W'(tok);
    row.want.queue_count      = CNT_W'(qc);
    return row;
  endfunction

  task automatic send_event(input logic kind, input logic [REQ_W-1:0] req,
                            input logic literal, input gate_result_t want);
    int           gap;
    gate_result_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.request <= req;
    do @(posedge clk); while (!in_ch.ready);
    pred = gate_predict(kind, req);
    pending_results.push_back(literal ? want : pred);
  endtask

  task automatic send_plain(input logic kind, input logic [REQ_W-1:0] req);
    send_event(kind, req, 1'b0, '0);
  endtask

  task automatic write_depth(input logic [REQ_W-1:0] d);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    bucket_depth = d;
  endtask

  task automatic report_mismatch(input string what, input gate_result_t want,
                                 input gate_result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: want st=%0d id=%0d rel=%0b rid=%0d rreq=%0d tok=%0d qc=%0d",
               $realtime, what, want.status, want.packet_id, want.released,
               want.released_id, want.released_request, want.tokens_now, want.queue_count);
      $display("%0t %s:  got st=%0d id=%0d rel=%0b rid=%0d rreq=%0d tok=%0d qc=%0d",
               $realtime, what, got.status, got.packet_id, got.released,
               got.released_id, got.released_request, got.tokens_now, got.queue_count);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    gate_result_t got;
    gate_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status           = status_t'(out_ch.status);
      got.packet_id        = out_ch.packet_id;
      got.released         = out_ch.released;
      got.released_id      = out_ch.released_id;
      got.released_request = out_ch.released_request;
      got.tokens_now       = out_ch.tokens_now;
      got.queue_count      = out_ch.queue_count;
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.packet_id !== want.packet_id ||
            got.released !== want.released || got.released_id !== want.released_id ||
            got.released_request !== want.released_request ||
            got.tokens_now !== want.tokens_now || got.queue_count !== want.queue_count)
          report_mismatch("result mismatch", want, got);
      end
    end
  end

  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!squeeze_done && results_seen >= SQUEEZE_AFTER && in_ch.valid) begin
        squeeze_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [REQ_W-1:0] phase_depth[NUM_PHASES];
    int               tick_pct;
    int               sent;
    int               mode;
    int               burst;
    int               k;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.kind    <= KIND_ARRIVAL;
    in_ch.request <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;

    bucket_depth  = DEPTH_RESET;
    bucket_tokens = '0;
    id_counter    = '0;

    plan.push_back(lit_row(KIND_ARRIVAL, 10'd1023, ST_TOO_BIG, 1, 0, 0, 0, 0, 0));
    plan.push_back(lit_row(KIND_ARRIVAL, 10'd11, ST_TOO_BIG, 2, 0, 0, 0, 0, 0));
    plan.push_back(lit_row(KIND_TICK, 10'd0, ST_TOKEN_ADDED, 0, 0, 0, 0, 1, 0));
    plan.push_back(lit_row(KIND_ARRIVAL, 10'd0, ST_QUEUED, 3, 1, 3, 0, 1, 0));
    plan.push_back(lit_row(KIND_ARRIVAL, 10'd2, ST_QUEUED, 4, 0, 0, 0, 1, 1));
    plan.push_back(lit_row(KIND_TICK, 10'd0, ST_TOKEN_ADDED, 0, 1, 4, 2, 0, 0));
    plan.push_back(step_row(KIND_ARRIVAL, 10'd2));
    plan.push_back(step_row(KIND_TICK, 10'd1023));
    plan.push_back(depth_row(10'd1));
    plan.push_back(lit_row(KIND_TICK, 10'd0, ST_TOKEN_DROPPED, 0, 0, 0, 0, 1, 1));
    plan.push_back(depth_row(10'd0));
    plan.push_back(lit_row(KIND_TICK, 10'h155, ST_TOKEN_DROPPED, 0, 0, 0, 0, 1, 1));
    plan.push_back(lit_row(KIND_ARRIVAL, 10'd1, ST_TOO_BIG, 6, 0, 0, 0, 1, 1));
    plan.push_back(lit_row(KIND_ARRIVAL, 10'd0, ST_QUEUED, 7, 0, 0, 0, 1, 2));
    plan.push_back(depth_row(10'd1022));
    plan.push_back(step_row(KIND_TICK, 10'h2AA));
    plan.push_back(step_row(KIND_TICK, 10'd0));
    plan.push_back(lit_row(KIND_ARRIVAL, 10'd1023, ST_TOO_BIG, 8, 0, 0, 0, 1, 0));
    plan.push_back(step_row(KIND_ARRIVAL, 10'd1));

    phase_depth[0] = 10'd1023;
    phase_depth[1] = 10'd10;
    phase_depth[2] = 10'd1;
    phase_depth[3] = 10'd0;
    phase_depth[4] = REQ_W'($urandom_range(2, 9));
    phase_depth[5] = 10'd1023;
    phase_depth[6] = 10'd3;
    phase_depth[7] = REQ_W'($urandom_range(100, 1000));
    phase_depth[8] = 10'd16;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].set_depth) begin
        write_depth(plan[i].depth_val);
      end else begin
        send_event(plan[i].kind, plan[i].request, plan[i].literal, plan[i].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_depth(phase_depth[ph]);
      quiet_link = (ph % 3 == 1);
      tick_pct   = $urandom_range(25, 75);
      sent       = 0;
      while (sent < PHASE_ITEMS) begin
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
          burst = $urandom_range(16, 20);
          repeat (burst) send_plain(KIND_ARRIVAL, pick_request(bucket_depth));
          sent += burst;
        end else if (mode == 1) begin
          burst = $urandom_range(8, 24);
          repeat (burst) send_plain(KIND_TICK, REQ_W'($urandom_range(0, 1023)));
          sent += burst;
        end else if ($urandom_range(0, 99) < tick_pct) begin
          send_plain(KIND_TICK, REQ_W'($urandom_range(0, 1023)));
          sent++;
        end else begin
          send_plain(KIND_ARRIVAL, pick_request(bucket_depth));
          sent++;
        end
      end
      // drain the waiting packets where the bucket can pay for them
      for (k = 0; k < 16 && held_q.size() != 0; k++)
        send_plain(KIND_TICK, REQ_W'($urandom_range(0, 1023)));
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/tbg_pkg.sv
src/tbg_if.sv
src/tbg_ram.sv
src/tbg_front.sv
src/tbg_cmd_fifo.sv
src/tbg_back.sv
src/token_bucket_packet_gate.sv
sim/tb_top.sv
